/* sv/tgrc_pkg.sv */
// Package for the touch grid relative cursor block: payload structs, the
// controller/datapath command and status structs, field widths and the pad tables.
// Depends on nothing; every other file imports it.
package tgrc_pkg;

  // Screen defaults for the top-level parameters.
  localparam int unsigned ScreenWidthDefault  = 320;
  localparam int unsigned ScreenHeightDefault = 240;

  // Field widths fixed by the payload.
  localparam int unsigned RawW   = 16;
  localparam int unsigned MapW   = 32;
  localparam int unsigned PtrXW  = 9;
  localparam int unsigned PtrYW  = 8;
  localparam int unsigned GainW  = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Internal arithmetic widths.
  localparam int unsigned PadIdxW = 5;
  localparam int unsigned CntW    = 6;   // up to 32 touched pads
  localparam int unsigned SumCW   = 6;   // column sum up to 48
  localparam int unsigned SumRW   = 7;   // row sum up to 112
  localparam int unsigned DvdW    = 11;  // ten times the row sum up to 1120
  localparam int unsigned RemW    = 7;
  localparam int unsigned CcW     = 5;   // column centroid in tenths, up to 30
  localparam int unsigned CrW     = 7;   // row centroid in tenths, up to 70
  localparam int unsigned DiffW   = 8;
  localparam int unsigned ProdW   = 17;
  localparam int unsigned MagW    = 16;
  localparam int unsigned DxW     = 12;

  // Pads examined per scan cycle and the number of scan cycles.
  localparam int unsigned PadsPerStep = 4;
  localparam int unsigned ScanSteps   = MapW / PadsPerStep;
  localparam int unsigned ScanIdxW    = $clog2(ScanSteps);

  // Division by ten: floor(n * 52429 / 2^19) is exact for every 16-bit n.
  localparam logic [MagW-1:0] RecipTen   = 16'd52429;
  localparam int unsigned     RecipShift = 19;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgPadMaskA = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPadMaskB = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgGainX    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgGainY    = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgTapLimit = 8'd4;

  // Register reset values.
  localparam logic [RawW-1:0]  PadMaskReset  = 16'hFFFF;
  localparam logic [GainW-1:0] GainReset     = 8'd20;
  localparam logic [GainW-1:0] TapLimitReset = 8'd15;

  // Grid column and row of each pad.
  localparam logic [1:0] PadCol [MapW] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0,
    2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0,
    2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3
  };
  localparam logic [2:0] PadRow [MapW] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd6,
    3'd7, 3'd7, 3'd7, 3'd7, 3'd5, 3'd5, 3'd5, 3'd5
  };

  typedef struct packed {
    logic [RawW-1:0] raw_chip_a;
    logic [RawW-1:0] raw_chip_b;
  } scan_in_t;

  typedef struct packed {
    logic [MapW-1:0]  pad_map;
    logic [PtrXW-1:0] pointer_x;
    logic [PtrYW-1:0] pointer_y;
    logic             contact;
    logic             tap_event;
  } scan_out_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic div_start;
    logic mul_step;
    logic scale_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
  } dp_status_t;

endpackage

/* sv/tgrc_div.sv */
// Two-lane restoring divider: both centroid sums divided by the pad count,
// one quotient bit per cycle. Depends on tgrc_pkg.
module tgrc_div import tgrc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_c_i,
  input  logic [DvdW-1:0] dividend_r_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quot_c_o,
  output logic [DvdW-1:0] quot_r_o
);

  localparam int unsigned StepW = $clog2(DvdW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [DvdW-1:0]  qc_q, qc_d, qr_q, qr_d;
  logic [RemW-1:0]  rc_q, rc_d, rr_q, rr_d;
  logic [RemW-1:0]  rc_sh, rr_sh, dvs_ext;

  // The quotient registers start out holding the dividends and shift them out.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    dvs_d   = dvs_q;
    qc_d    = qc_q;
    qr_d    = qr_q;
    rc_d    = rc_q;
    rr_d    = rr_q;
    dvs_ext = {{(RemW - CntW){1'b0}}, dvs_q};
    rc_sh   = {rc_q[RemW-2:0], qc_q[DvdW-1]};
    rr_sh   = {rr_q[RemW-2:0], qr_q[DvdW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(DvdW);
      dvs_d  = divisor_i;
      qc_d   = dividend_c_i;
      qr_d   = dividend_r_i;
      rc_d   = '0;
      rr_d   = '0;
    end else if (busy_q) begin
      if (rc_sh >= dvs_ext) begin
        rc_d = rc_sh - dvs_ext;
        qc_d = {qc_q[DvdW-2:0], 1'b1};
      end else begin
        rc_d = rc_sh;
        qc_d = {qc_q[DvdW-2:0], 1'b0};
      end
      if (rr_sh >= dvs_ext) begin
        rr_d = rr_sh - dvs_ext;
        qr_d = {qr_q[DvdW-2:0], 1'b1};
      end else begin
        rr_d = rr_sh;
        qr_d = {qr_q[DvdW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    qc_q  <= qc_d;
    qr_q  <= qr_d;
    rc_q  <= rc_d;
    rr_q  <= rr_d;
  end

  assign done_o   = done_q;
  assign quot_c_o = qc_q;
  assign quot_r_o = qr_q;

endmodule

/* sv/tgrc_datapath.sv */
// Datapath: configuration registers, pad map, centroid sums, divider, gain
// scaling, cursor state and the output register. Depends on tgrc_pkg, tgrc_div.
module tgrc_datapath import tgrc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  scan_in_t            in_data_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output scan_out_t           out_data_o
);

  localparam int unsigned CWX  = $clog2(SCREEN_WIDTH);
  localparam int unsigned CWY  = $clog2(SCREEN_HEIGHT);
  localparam int unsigned SXW  = CWX + DxW;
  localparam int unsigned SYW  = CWY + DxW;
  localparam int unsigned TWA  = (CWX > CWY) ? CWX : CWY;
  localparam int unsigned TW   = (TWA > GainW) ? TWA : GainW;

  // Configuration registers.
  logic [RawW-1:0]  mask_a_q, mask_b_q;
  logic [GainW-1:0] gain_x_q, gain_y_q, tap_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_a_q    <= PadMaskReset;
      mask_b_q    <= PadMaskReset;
      gain_x_q    <= GainReset;
      gain_y_q    <= GainReset;
      tap_limit_q <= TapLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPadMaskA: mask_a_q <= cfg_data_i;
        CfgPadMaskB: mask_b_q <= cfg_data_i;
        CfgGainX: begin
          if (cfg_data_i[GainW-1:0] != '0) gain_x_q <= cfg_data_i[GainW-1:0];
        end
        CfgGainY: begin
          if (cfg_data_i[GainW-1:0] != '0) gain_y_q <= cfg_data_i[GainW-1:0];
        end
        CfgTapLimit: tap_limit_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Pad map: masked active-low words, bit-reversed.
  logic [RawW-1:0] touch_a, touch_b;
  logic [MapW-1:0] map_new;

  always_comb begin
    touch_a = ~in_data_i.raw_chip_a & mask_a_q;
    touch_b = ~in_data_i.raw_chip_b & mask_b_q;
    for (int i = 0; i < RawW; i++) begin
      map_new[i]        = touch_a[RawW-1-i];
      map_new[RawW + i] = touch_b[RawW-1-i];
    end
  end

  // Scan: a few pads per cycle into count and sums.
  logic [MapW-1:0]     map_q, pend_q;
  logic [ScanIdxW-1:0] scan_idx_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [SumCW-1:0]    sum_c_q, sum_c_d;
  logic [SumRW-1:0]    sum_r_q, sum_r_d;
  logic [PadIdxW-1:0]  pad_idx [PadsPerStep];

  always_comb begin
    count_d = count_q;
    sum_c_d = sum_c_q;
    sum_r_d = sum_r_q;
    for (int j = 0; j < PadsPerStep; j++) begin
      pad_idx[j] = PadIdxW'({scan_idx_q, 2'(j)});
      if (pend_q[j]) begin
        count_d = count_d + CntW'(1);
        sum_c_d = sum_c_d + SumCW'(PadCol[pad_idx[j]]);
        sum_r_d = sum_r_d + SumRW'(PadRow[pad_idx[j]]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_q      <= map_new;
      pend_q     <= map_new;
      scan_idx_q <= '0;
      count_q    <= '0;
      sum_c_q    <= '0;
      sum_r_q    <= '0;
    end else if (cmd_i.scan_step) begin
      pend_q     <= pend_q >> PadsPerStep;
      scan_idx_q <= scan_idx_q + ScanIdxW'(1);
      count_q    <= count_d;
      sum_c_q    <= sum_c_d;
      sum_r_q    <= sum_r_d;
    end
  end

  logic scan_last, div_done;

  assign scan_last = (scan_idx_q == ScanIdxW'(ScanSteps - 1));

  // Centroids in tenths: ten times each sum divided by the count.
  logic [DvdW-1:0] dvd_c, dvd_r, quot_c, quot_r;

  assign dvd_c = DvdW'({sum_c_q, 3'b000}) + DvdW'({sum_c_q, 1'b0});
  assign dvd_r = DvdW'({sum_r_q, 3'b000}) + DvdW'({sum_r_q, 1'b0});

  tgrc_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cmd_i.div_start),
    .dividend_c_i (dvd_c),
    .dividend_r_i (dvd_r),
    .divisor_i    (count_q),
    .done_o       (div_done),
    .quot_c_o     (quot_c),
    .quot_r_o     (quot_r)
  );

  assign status_o = '{scan_last: scan_last, div_done: div_done};

  logic [CcW-1:0] cc;
  logic [CrW-1:0] cr;
  assign cc = quot_c[CcW-1:0];
  assign cr = quot_r[CrW-1:0];

  // Architectural state.
  logic           tracking_q;
  logic [CWX-1:0] cur_x_q, start_x_q;
  logic [CWY-1:0] cur_y_q, start_y_q;
  logic [CcW-1:0] prev_c_q;
  logic [CrW-1:0] prev_r_q;

  // Centroid change times gain.
  logic signed [DiffW-1:0] diff_c, diff_r;
  logic signed [GainW:0]   gx_s, gy_s;
  logic signed [ProdW-1:0] prod_x_q, prod_y_q;

  assign diff_c = $signed({{(DiffW - CcW){1'b0}}, cc})
                - $signed({{(DiffW - CcW){1'b0}}, prev_c_q});
  assign diff_r = $signed({{(DiffW - CrW){1'b0}}, cr})
                - $signed({{(DiffW - CrW){1'b0}}, prev_r_q});
  assign gx_s = $signed({1'b0, gain_x_q});
  assign gy_s = $signed({1'b0, gain_y_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_x_q <= ProdW'(diff_c) * ProdW'(gx_s);
      prod_y_q <= ProdW'(diff_r) * ProdW'(gy_s);
    end
  end

  // Divide by ten toward zero: magnitude times reciprocal, then the sign again.
  logic [MagW-1:0]     mag_px, mag_py;
  logic [2*MagW-1:0]   rcp_x, rcp_y;
  logic [DxW-2:0]      qx, qy;
  logic signed [DxW-1:0] dx_q, dy_q;

  always_comb begin
    mag_px = prod_x_q[ProdW-1] ? MagW'(-prod_x_q) : prod_x_q[MagW-1:0];
    mag_py = prod_y_q[ProdW-1] ? MagW'(-prod_y_q) : prod_y_q[MagW-1:0];
    rcp_x  = (2*MagW)'(mag_px) * (2*MagW)'(RecipTen);
    rcp_y  = (2*MagW)'(mag_py) * (2*MagW)'(RecipTen);
    qx     = rcp_x[RecipShift +: DxW-1];
    qy     = rcp_y[RecipShift +: DxW-1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_step) begin
      dx_q <= prod_x_q[ProdW-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      dy_q <= prod_y_q[ProdW-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
  end

  // Cursor move with clamping to the screen.
  logic signed [SXW-1:0] sum_x;
  logic signed [SYW-1:0] sum_y;
  logic [CWX-1:0]        moved_x;
  logic [CWY-1:0]        moved_y;

  always_comb begin
    sum_x = $signed({{DxW{1'b0}}, cur_x_q}) + $signed({{CWX{dx_q[DxW-1]}}, dx_q});
    sum_y = $signed({{DxW{1'b0}}, cur_y_q}) + $signed({{CWY{dy_q[DxW-1]}}, dy_q});
    if (sum_x[SXW-1]) begin
      moved_x = '0;
    end else if (sum_x >= $signed(SXW'(SCREEN_WIDTH))) begin
      moved_x = CWX'(SCREEN_WIDTH - 1);
    end else begin
      moved_x = sum_x[CWX-1:0];
    end
    if (sum_y[SYW-1]) begin
      moved_y = '0;
    end else if (sum_y >= $signed(SYW'(SCREEN_HEIGHT))) begin
      moved_y = CWY'(SCREEN_HEIGHT - 1);
    end else begin
      moved_y = sum_y[CWY-1:0];
    end
  end

  // Chebyshev distance since touch-down, for the tap decision on release.
  logic signed [CWX:0] dist_x;
  logic signed [CWY:0] dist_y;
  logic [TW-1:0]       mvx, mvy, mv;
  logic                tap_hit;

  always_comb begin
    dist_x  = $signed({1'b0, cur_x_q}) - $signed({1'b0, start_x_q});
    dist_y  = $signed({1'b0, cur_y_q}) - $signed({1'b0, start_y_q});
    mvx     = TW'(dist_x[CWX] ? CWX'(-dist_x) : dist_x[CWX-1:0]);
    mvy     = TW'(dist_y[CWY] ? CWY'(-dist_y) : dist_y[CWY-1:0]);
    mv      = (mvx > mvy) ? mvx : mvy;
    tap_hit = mv < TW'(tap_limit_q);
  end

  // Commit of one scan.
  logic           has_touch;
  logic           tracking_d, tap_d;
  logic [CWX-1:0] cur_x_d;
  logic [CWY-1:0] cur_y_d;

  assign has_touch = (count_q != '0);

  always_comb begin
    tracking_d = tracking_q;
    tap_d      = 1'b0;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    if (has_touch) begin
      tracking_d = 1'b1;
      if (tracking_q) begin
        cur_x_d = moved_x;
        cur_y_d = moved_y;
      end
    end else if (tracking_q) begin
      tracking_d = 1'b0;
      tap_d      = tap_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      cur_x_q    <= CWX'(SCREEN_WIDTH / 2);
      cur_y_q    <= CWY'(SCREEN_HEIGHT / 2);
      start_x_q  <= '0;
      start_y_q  <= '0;
      prev_c_q   <= '0;
      prev_r_q   <= '0;
    end else if (cmd_i.commit) begin
      tracking_q <= tracking_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      if (has_touch) begin
        prev_c_q <= cc;
        prev_r_q <= cr;
        if (!tracking_q) begin
          start_x_q <= cur_x_q;
          start_y_q <= cur_y_q;
        end
      end
    end
  end

  scan_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.pad_map   <= map_q;
      out_q.pointer_x <= PtrXW'(cur_x_d);
      out_q.pointer_y <= PtrYW'(cur_y_d);
      out_q.contact   <= tracking_d;
      out_q.tap_event <= tap_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* sv/tgrc_ctrl.sv */
// Controller: sequences one scan through map, sums, divide, multiply, scale and commit,
// and owns the input ready and output valid. Depends on tgrc_pkg.
module tgrc_ctrl import tgrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DSTART = 7'b0000100,
    S_DIVIDE = 7'b0001000,
    S_MULT   = 7'b0010000,
    S_SCALE  = 7'b0100000,
    S_COMMIT = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register may be refilled in the cycle its beat leaves.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status_i.div_done) state_d = S_MULT;
      end
      S_MULT: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale_step = 1'b1;
        state_d          = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/touch_grid_relative_cursor_core.sv */
// Top level of the touch grid relative cursor block: controller plus datapath.
// Depends on tgrc_pkg, tgrc_ctrl, tgrc_datapath (and through it tgrc_div).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per scan:
//   the two raw active-low pad words of the sensor chips. Output channel
//   (out_valid_o / out_ready_i / out_data_o) returns exactly one beat per scan:
//   the masked pad map, the cursor position, the contact flag and the tap flag.
//   Configuration writes (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//   are always taken; they should be issued only while no scan is in flight.
//   Writes to unknown indexes are dropped, and a zero gain leaves the gain as is.
//
//   Each scan runs in order from input acceptance to the result beat: the pad
//   columns and rows are summed four pads at a time, the divider is started, the
//   restoring divider turns the sums into centroids (eleven quotient bits at one
//   per cycle), then come the gain multiply, the divide by ten and the commit into
//   the output register. Scans are processed one at a time: the controller takes
//   the next beat only in its idle state after the commit, so it cannot accept a
//   new scan before it is through with the last one.
//
//   A result waits in the output register while the receiver stalls; the next
//   scan is still accepted and worked on, and it only holds at its commit step
//   until the waiting beat has gone. Reset clears the handshake, puts the cursor
//   at the screen center, leaves tracking off and restores the register defaults.
module touch_grid_relative_cursor_core import tgrc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scan_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scan_out_t           out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes never stall; software must write to an idle block, unchecked.
  assign cfg_ready_o = 1'b1;

  tgrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tgrc_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/tgrc_checker.sv */
// Port-level checker for the touch grid relative cursor block, bound to the
// top level. Depends on tgrc_pkg and touch_grid_relative_cursor_core.
module tgrc_checker import tgrc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input scan_out_t           out_data_o
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Scans are processed one at a time: no new beat right after one is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a scan was in flight");

  // A tap ends a touch, so contact is off on the same beat.
  a_tap_ends_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tap_event |-> !out_data_o.contact)
    else $error("tap reported while still in contact");

  // The cursor stays on the screen where the field can show it whole.
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (SCREEN_WIDTH <= 512) && (SCREEN_HEIGHT <= 256)
    |-> (32'(out_data_o.pointer_x) < SCREEN_WIDTH)
     && (32'(out_data_o.pointer_y) < SCREEN_HEIGHT))
    else $error("cursor outside the screen");

endmodule

bind touch_grid_relative_cursor_core tgrc_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tgrc_checker (.*);

/* tb/touch_grid_relative_cursor_core_tb.sv */
// Self-checking testbench for touch_grid_relative_cursor_core: scan beats in,
// cursor reports out, each report checked against a cycle-free cursor predictor.
// Depends on tgrc_pkg for the payload structs, widths and register indexes.
module touch_grid_relative_cursor_core_tb;
  import tgrc_pkg::*;

  localparam int ScreenW      = ScreenWidthDefault;
  localparam int ScreenH      = ScreenHeightDefault;
  localparam int GapMax       = 14;
  // Watchdog limit, well above what a correct run needs.
  localparam int CycleLimit   = 400000;
  // Settle time at the end, long enough for any straggler beat to show.
  localparam int SettleCycles = 60;

  // Indexes past the register list; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgIndexTop = 8'hFF;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  scan_in_t            in_data_i   = '1;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  scan_out_t           out_data_o;

  touch_grid_relative_cursor_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor copy of the registers, starting from their reset values.
  logic [RawW-1:0] pad_enable_a  = PadMaskReset;
  logic [RawW-1:0] pad_enable_b  = PadMaskReset;
  int              col_gain      = int'(GainReset);
  int              row_gain      = int'(GainReset);
  int              tap_threshold = int'(TapLimitReset);

  // Predictor copy of the tracking state.
  bit in_contact  = 1'b0;
  int ptr_col     = ScreenW / 2;
  int ptr_row     = ScreenH / 2;
  int last_cent_x = 0;
  int last_cent_y = 0;
  int anchor_x    = 0;
  int anchor_y    = 0;

  // Reports predicted for accepted scans, oldest first.
  scan_out_t cursor_reports_q[$];

  int error_count   = 0;
  int scans_sent    = 0;
  int cycle_count   = 0;
  // Upper bounds of the random gaps each side draws per beat; zero gives
  // stretches with the channel running flat out.
  int send_gap_max  = GapMax;
  int take_gap_max  = GapMax;
  // A test sets this to ask the receiver for one long hold-off.
  int hold_request  = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  // Pads sit on a 4-wide grid in groups of four. Groups one and two run right
  // to left, groups zero and three left to right. The second chip repeats the
  // first chip's layout four rows lower.
  function automatic int pad_column(int pad);
    int slot;
    slot = pad % 4;
    case ((pad / 4) % 4)
      1, 2: return 3 - slot;
      default: return slot;
    endcase
  endfunction

  function automatic int pad_row(int pad);
    int base;
    case ((pad / 4) % 4)
      0: base = 0;
      1: base = 2;
      2: base = 3;
      default: base = 1;
    endcase
    return (pad >= 16) ? base + 4 : base;
  endfunction

  function automatic int fit_axis(int pos, int span);
    if (pos < 0) return 0;
    if (pos >= span) return span - 1;
    return pos;
  endfunction

  // Register writes as the block applies them: a gain whose low byte is zero is
  // refused, wide data is cut to the register, and unknown indexes do nothing.
  function automatic void apply_register(logic [CfgIdxW-1:0] idx,
                                         logic [CfgDataW-1:0] data);
    case (idx)
      CfgPadMaskA: pad_enable_a = data;
      CfgPadMaskB: pad_enable_b = data;
      CfgGainX:    if (data[7:0] != 8'd0) col_gain = int'(data[7:0]);
      CfgGainY:    if (data[7:0] != 8'd0) row_gain = int'(data[7:0]);
      CfgTapLimit: tap_threshold = int'(data[7:0]);
      default: ;
    endcase
  endfunction

  // Works out the report for one scan and advances the tracking state.
  function automatic scan_out_t predict_cursor_report(scan_in_t scan);
    logic [RawW-1:0] hit_a, hit_b;
    logic [MapW-1:0] touched;
    int        sum_x, sum_y, pads, cent_x, cent_y, step_x, step_y, dist_x, dist_y;
    scan_out_t rep;
    hit_a = ~scan.raw_chip_a & pad_enable_a;
    hit_b = ~scan.raw_chip_b & pad_enable_b;
    // Word bit 15 is the chip's first pad, so the map is each word reversed.
    for (int i = 0; i < 16; i++) begin
      touched[i]      = hit_a[15-i];
      touched[16 + i] = hit_b[15-i];
    end
    sum_x = 0;
    sum_y = 0;
    pads  = 0;
    for (int p = 0; p < MapW; p++) begin
      if (touched[p]) begin
        sum_x += pad_column(p);
        sum_y += pad_row(p);
        pads++;
      end
    end
    rep = '0;
    rep.pad_map = touched;
    if (pads > 0) begin
      // Centroid in tenths of a grid step, rounded down.
      cent_x = (sum_x * 10) / pads;
      cent_y = (sum_y * 10) / pads;
      if (!in_contact) begin
        // Touch-down only records where the touch began; the cursor stays.
        anchor_x   = ptr_col;
        anchor_y   = ptr_row;
        in_contact = 1'b1;
      end else begin
        // Division of a signed int truncates toward zero, as the block does.
        step_x  = ((cent_x - last_cent_x) * col_gain) / 10;
        step_y  = ((cent_y - last_cent_y) * row_gain) / 10;
        ptr_col = fit_axis(ptr_col + step_x, ScreenW);
        ptr_row = fit_axis(ptr_row + step_y, ScreenH);
      end
      last_cent_x = cent_x;
      last_cent_y = cent_y;
    end else if (in_contact) begin
      // Release: a tap when the larger axis movement stays under the limit.
      // A limit of zero can never be undercut.
      dist_x = (ptr_col > anchor_x) ? ptr_col - anchor_x : anchor_x - ptr_col;
      dist_y = (ptr_row > anchor_y) ? ptr_row - anchor_y : anchor_y - ptr_row;
      rep.tap_event = ((dist_x > dist_y ? dist_x : dist_y) < tap_threshold);
      in_contact    = 1'b0;
    end
    rep.pointer_x = ptr_col[PtrXW-1:0];
    rep.pointer_y = ptr_row[PtrYW-1:0];
    rep.contact   = in_contact;
    return rep;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_report(scan_out_t got);
    scan_out_t want;
    if (cursor_reports_q.size() == 0) begin
      $display("%0t: report beat with no scan waiting for it: expected none, actual %h",
               $time, got);
      error_count++;
    end else begin
      want = cursor_reports_q.pop_front();
      check_field("pad_map",   want.pad_map,            got.pad_map);
      check_field("pointer_x", 32'(want.pointer_x),     32'(got.pointer_x));
      check_field("pointer_y", 32'(want.pointer_y),     32'(got.pointer_y));
      check_field("contact",   32'(want.contact),       32'(got.contact));
      check_field("tap_event", 32'(want.tap_event),     32'(got.tap_event));
    end
  endfunction

  // Receiver. Outputs are sampled at the edge, before the block's own updates
  // land. After every beat it draws a stall; a hold-off request from a test
  // overrides that and keeps ready low for the whole stretch, counted here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_report(out_data_o);
        stall_left = $urandom_range(0, take_gap_max);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: no progress within %0d cycles", $time, CycleLimit);
    $display("** touch_grid_relative_cursor_core: FAILED **");
    $finish;
  end

  // One register write beat. Valid is left high so that back-to-back writes
  // keep it steady; whoever ends a burst of writes drops it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
  endtask

  // Writes all five registers. The 8-bit ones carry junk in the upper byte,
  // which the block must cut away.
  task automatic load_settings(input logic [RawW-1:0] ma, input logic [RawW-1:0] mb,
                               input logic [7:0] gx, input logic [7:0] gy,
                               input logic [7:0] tl);
    logic [7:0] junk;
    junk = 8'($urandom);
    write_reg(CfgPadMaskA, ma);
    write_reg(CfgPadMaskB, mb);
    write_reg(CfgGainX, {junk, gx});
    write_reg(CfgGainY, {~junk, gy});
    write_reg(CfgTapLimit, {junk, tl});
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one scan beat after a random gap. Valid is only dropped when a gap
  // follows, so back-to-back beats never see it lowered and raised in one step.
  task automatic send_scan(input scan_in_t scan);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= scan;
    do @(posedge clk_i); while (!in_ready_o);
    cursor_reports_q.push_back(predict_cursor_report(scan));
    scans_sent++;
  endtask

  // Sender pause: drops valid in the step of the last beat and waits until
  // every report is back, leaving the block idle for register writes.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (cursor_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // Raw words for a set of touched pads, bit p meaning pad p is pressed.
  function automatic scan_in_t pads_touched(logic [MapW-1:0] pads);
    scan_in_t s;
    for (int i = 0; i < 16; i++) begin
      s.raw_chip_a[15-i] = ~pads[i];
      s.raw_chip_b[15-i] = ~pads[16 + i];
    end
    return s;
  endfunction

  function automatic logic [MapW-1:0] random_finger();
    logic [MapW-1:0] pads;
    int              n;
    pads = '0;
    n    = $urandom_range(1, 4);
    repeat (n) pads[$urandom_range(0, MapW - 1)] = 1'b1;
    return pads;
  endfunction

  // A touch-down, a few moves and a release. A steady finger keeps its pads so
  // the release is a tap unless the limit is zero; others wander or add a pad.
  task automatic send_gesture();
    logic [MapW-1:0] spot;
    int              moves;
    bit              steady;
    spot   = random_finger();
    moves  = $urandom_range(0, 8);
    steady = ($urandom_range(0, 3) == 0);
    send_scan(pads_touched(spot));
    repeat (moves) begin
      if (!steady) begin
        if ($urandom_range(0, 1) == 0) spot = random_finger();
        else spot = spot | (32'h1 << $urandom_range(0, MapW - 1));
      end
      send_scan(pads_touched(spot));
    end
    send_scan(pads_touched('0));
  endtask

  // Reset defaults: idle scans, a touch-down that must not move the cursor,
  // a drag across the grid, all pads at once, and releases with and without
  // movement.
  task automatic test_power_on();
    send_scan(pads_touched('0));
    send_scan(pads_touched(32'h0000_0001));
    send_scan(pads_touched(32'h0000_0008));
    send_scan(pads_touched('1));
    send_scan(pads_touched('0));
    send_scan(pads_touched(32'h0001_0000));
    send_scan(pads_touched(32'h0001_0000));
    send_scan(pads_touched('0));
    wait_for_results();
  endtask

  // Register corner cases, clamping at both screen edges, truncation of tiny
  // scaled steps toward zero, and each chip masked off in turn.
  task automatic test_register_corners();
    // Refused or dropped writes: gain of zero, gain whose low byte is zero,
    // unknown indexes. Tap limit of zero arrives with junk in the upper byte.
    write_reg(CfgGainX, 16'h0000);
    write_reg(CfgGainY, 16'hAB00);
    write_reg(CfgUnmapped, 16'h0000);
    write_reg(CfgIndexTop, 16'hFFFF);
    write_reg(CfgTapLimit, 16'hFF00);
    cfg_valid_i <= 1'b0;
    // Still gains of 20; the release cannot count as a tap with a zero limit.
    send_scan(pads_touched(32'h0000_0020));
    send_scan(pads_touched(32'h0000_0020));
    send_scan(pads_touched('0));
    wait_for_results();

    // Largest gains drive the cursor hard into opposite corners.
    load_settings(16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255);
    send_scan(pads_touched(32'h0000_0001));
    send_scan(pads_touched(32'h0100_0000));
    send_scan(pads_touched(32'h0000_0001));
    send_scan(pads_touched(32'h0100_0000));
    send_scan(pads_touched('0));
    wait_for_results();

    // Unit gains with the first chip masked: half-step moves truncate to zero
    // in both directions, and the pads of the first chip read as untouched.
    load_settings(16'h0000, 16'hFFFF, 8'd1, 8'd1, 8'd15);
    send_scan(pads_touched(32'h0001_FFFF));
    send_scan(pads_touched(32'h0003_0000));
    send_scan(pads_touched(32'h0001_0000));
    send_scan(pads_touched(32'h0008_0000));
    send_scan(pads_touched('0));
    wait_for_results();

    // Second chip masked: raw words of all zeros only show the first chip.
    load_settings(16'hFFFF, 16'h0000, 8'd20, 8'd20, 8'd15);
    send_scan('0);
    send_scan(pads_touched('0));
    wait_for_results();
    load_settings(PadMaskReset, PadMaskReset, GainReset, GainReset, TapLimitReset);
  endtask

  // The receiver holds off for a long stretch while scans keep coming
  // back to back, so the block fills and must stall its input.
  task automatic test_backpressure();
    hold_request = 300;
    send_gap_max = 0;
    send_scan(pads_touched(32'h0000_0001));
    for (int k = 0; k < 10; k++) send_scan(pads_touched(random_finger()));
    send_scan(pads_touched('0));
    send_gap_max = GapMax;
    wait_for_results();
  endtask

  // New register values for one phase of random traffic; some phases pin a
  // gain or the tap limit to an extreme.
  task automatic randomize_settings(input int phase);
    logic [RawW-1:0] ma, mb;
    logic [7:0]      gx, gy, tl;
    ma = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom | $urandom);
    mb = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
    gx = 8'($urandom_range(1, 255));
    gy = 8'($urandom_range(1, 255));
    tl = 8'($urandom_range(0, 60));
    case (phase)
      0: begin
        gx = 8'd1;
        gy = 8'd255;
      end
      2: begin
        gx = 8'd255;
        gy = 8'd1;
      end
      3: tl = 8'd0;
      5: tl = 8'd255;
      default: ;
    endcase
    // Now and then a refused zero gain goes in first.
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CfgGainX, {8'($urandom), 8'h00});
      write_reg(CfgGainY, {8'($urandom), 8'h00});
    end
    load_settings(ma, mb, gx, gy, tl);
  endtask

  // Mostly gestures with random pads, with raw noise words mixed in. Some phases
  // use random gaps on both sides, others none, and one only on the send side.
  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 8; phase++) begin
      randomize_settings(phase);
      send_gap_max = (phase % 3 == 1) ? 0 : GapMax;
      take_gap_max = (phase % 3 == 1 || phase == 3) ? 0 : GapMax;
      target = scans_sent + 100;
      while (scans_sent < target) begin
        if ($urandom_range(0, 4) == 0) send_scan(scan_in_t'($urandom));
        else send_gesture();
      end
      wait_for_results();
    end
    send_gap_max = GapMax;
    take_gap_max = GapMax;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_power_on();
    test_register_corners();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    // Any late or extra beat during this settle time is caught by the receiver.
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** touch_grid_relative_cursor_core: PASSED **");
    end else begin
      $display("** touch_grid_relative_cursor_core: FAILED **");
    end
    $finish;
  end

endmodule
